[hw/rtl/ase_pkg.sv]
`default_nettype none
package ase_pkg;

    localparam int MAX_RESULTS = 40;
    localparam int RES_W       = 6;
    localparam int TV_W        = 16;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_PEND  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_SYMBOL_COUNT = 2'd0,
        CFG_START_OFFSET = 2'd1,
        CFG_START_PREFIX = 2'd2
    } t_cfg_index;

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_ENCODE = 1'b1
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOT,
        S_CLO,
        S_CHI,
        S_MUL,
        S_DIVS,
        S_DIV,
        S_CHK,
        S_REN,
        S_PUT,
        S_FLUSH,
        S_TAIL,
        S_ORD,
        S_OLD,
        S_OWAIT
    } t_state;

endpackage
`default_nettype wire

[hw/rtl/ase_if.sv]
`default_nettype none
interface ase_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface ase_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [8:0]  table_index;
    logic [15:0] table_value;
    logic [7:0]  symbol;
    logic        last;
    modport source (output valid, action, table_index, table_value, symbol, last,
                    input ready);
    modport sink   (input valid, action, table_index, table_value, symbol, last,
                    output ready);
endinterface

interface ase_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic        byte_valid;
    logic [1:0]  status;
    logic        stream_end;
    logic [31:0] bit_length;
    logic        end_of_run;
    modport source (output valid, byte_value, byte_valid, status, stream_end, bit_length,
                    end_of_run, input ready);
    modport sink   (input valid, byte_value, byte_valid, status, stream_end, bit_length,
                    end_of_run, output ready);
endinterface
`default_nettype wire

[hw/rtl/arithmetic_symbol_encoder.sv]
// Integer arithmetic encoder. Input transfers either write one word of the
// cumulative frequency table (kept in a synchronous RAM with separate read and
// write ports) or encode one symbol. A table write gives one result. An encode
// does three table reads, a multiply and two restoring dividers run side by
// side (one quotient bit a cycle), then the renormalization steps and output
// bits one by one, then the result transfers. Results are buffered (up to 40
// bytes) and sent after the symbol is fully coded, so every result of an item
// carries its final status.
// Configuration writes are always taken and must only occur while idle.
`default_nettype none
module arithmetic_symbol_encoder
    import ase_pkg::*;
#(
    parameter int MAX_SYMBOLS = 256,
    parameter int CODE_BITS   = 16,
    parameter int MAX_PENDING = 127
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ase_cfg_if.sink   i_cfg,
    ase_in_if.sink    i_in,
    ase_out_if.source o_out
);
    localparam int CB = CODE_BITS;
    localparam int PW = CB + 17;
    localparam int AW = $clog2(MAX_SYMBOLS + 1);
    localparam int CW = 14;
    localparam int PB = $clog2(MAX_PENDING + 1);
    localparam logic [CB-1:0] Q1 = CB'(1) << (CB - 2);

    logic [TV_W-1:0] m_tab [0:MAX_SYMBOLS];
    logic [7:0]      m_res [0:MAX_RESULTS-1];

    t_state          r_state, n_state;
    logic [8:0]      r_sc;
    logic [2:0]      r_off;
    logic [7:0]      r_pre;
    logic [CB-1:0]   r_low, n_low, r_high, n_high;
    logic [PB-1:0]   r_pend, n_pend;
    logic [7:0]      r_buf, n_buf;
    logic [3:0]      r_btg, n_btg;
    logic [31:0]     r_bytes, n_bytes;
    logic            r_open, n_open;
    logic [7:0]      r_sym, n_sym;
    logic            r_last, n_last;
    logic [TV_W-1:0] r_total, n_total, r_clo, n_clo, r_chi, n_chi;
    logic [PW-1:0]   r_prod0, n_prod0, r_prod1, n_prod1;
    t_status         r_status, n_status;
    logic [RES_W-1:0] r_nres, n_nres, r_oidx, n_oidx;
    logic            r_bit, n_bit, r_inv, n_inv, r_flush, n_flush, r_final, n_final;
    logic [PB:0]     r_follow, n_follow;
    logic [31:0]     r_len, n_len;
    logic [TV_W-1:0] r_tdata;
    logic [7:0]      r_rbdata;
    logic            r_ovalid, n_ovalid;
    logic [7:0]      r_obyte, n_obyte;
    logic            r_obv, n_obv, r_oend, n_oend, r_oeor, n_oeor;
    logic [31:0]     r_olen, n_olen;

    logic            tab_we;
    logic [AW-1:0]   tab_wa;
    logic [AW-1:0]   rd_addr;
    logic            rb_we;
    logic [7:0]      rb_wd;
    logic            div_start;
    logic            div0_done, div1_done;
    logic [PW-1:0]   q0, q1;
    logic [CW-1:0]   count_c;
    logic [CB:0]     range_w;
    logic [PW:0]     lo_w, hi1_w;
    logic            cur;
    logic [7:0]      nb;
    logic [35:0]     len_w;
    logic            islast;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc  <= 9'd256;
            r_off <= '0;
            r_pre <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SYMBOL_COUNT: r_sc  <= i_cfg.data;
                CFG_START_OFFSET: r_off <= i_cfg.data[2:0];
                CFG_START_PREFIX: r_pre <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            m_tab[tab_wa] <= i_in.table_value;
        end
        r_tdata <= m_tab[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rb_we) begin
            m_res[r_nres] <= rb_wd;
        end
        r_rbdata <= m_res[r_oidx];
    end

    ase_div #(.NW(PW)) u_div0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(r_prod0), .i_divisor(r_total), .o_done(div0_done), .o_quot(q0)
    );

    ase_div #(.NW(PW)) u_div1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(r_prod1), .i_divisor(r_total), .o_done(div1_done), .o_quot(q1)
    );

    always_comb begin
        count_c = (CW'(r_sc) > CW'(MAX_SYMBOLS)) ? CW'(MAX_SYMBOLS) : CW'(r_sc);
        range_w = {1'b0, r_high} - {1'b0, r_low} + 1'b1;
        lo_w    = (PW+1)'(r_low) + (PW+1)'(q0);
        hi1_w   = (PW+1)'(r_low) + (PW+1)'(q1);
        cur     = r_bit ^ r_inv;
        nb      = {r_buf[6:0], cur};
        len_w   = {1'b0, r_bytes, 3'b000} + 36'(4'd8 - r_btg) - 36'(r_off);
        islast  = (r_nres == '0) || (r_oidx == r_nres - 1'b1);
    end

    always_comb begin
        n_state  = r_state;
        n_low    = r_low;
        n_high   = r_high;
        n_pend   = r_pend;
        n_buf    = r_buf;
        n_btg    = r_btg;
        n_bytes  = r_bytes;
        n_open   = r_open;
        n_sym    = r_sym;
        n_last   = r_last;
        n_total  = r_total;
        n_clo    = r_clo;
        n_chi    = r_chi;
        n_prod0  = r_prod0;
        n_prod1  = r_prod1;
        n_status = r_status;
        n_nres   = r_nres;
        n_oidx   = r_oidx;
        n_bit    = r_bit;
        n_inv    = r_inv;
        n_flush  = r_flush;
        n_final  = r_final;
        n_follow = r_follow;
        n_len    = r_len;
        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_obv    = r_obv;
        n_oend   = r_oend;
        n_oeor   = r_oeor;
        n_olen   = r_olen;
        tab_we   = 1'b0;
        tab_wa   = AW'(i_in.table_index);
        rd_addr  = AW'(r_sym);
        rb_we    = 1'b0;
        rb_wd    = nb;
        div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                rd_addr = AW'(count_c);
                if (i_in.valid) begin
                    n_status = ST_OK;
                    n_nres   = '0;
                    n_oidx   = '0;
                    n_final  = 1'b0;
                    n_len    = '0;
                    n_state  = S_ORD;
                    if (i_in.action == ACT_WRITE) begin
                        tab_we = CW'(i_in.table_index) <= CW'(MAX_SYMBOLS);
                    end else if (CW'(i_in.symbol) >= count_c) begin
                        n_status = ST_RANGE;
                    end else begin
                        n_sym   = i_in.symbol;
                        n_last  = i_in.last;
                        n_state = S_TOT;
                        if (!r_open) begin
                            n_low   = '0;
                            n_high  = '1;
                            n_pend  = '0;
                            n_bytes = '0;
                            n_btg   = 4'd8 - {1'b0, r_off};
                            n_buf   = r_pre >> (4'd8 - {1'b0, r_off});
                        end
                    end
                end
            end
            S_TOT: begin
                n_total = r_tdata;
                rd_addr = AW'(r_sym);
                n_state = S_CLO;
            end
            S_CLO: begin
                n_clo   = r_tdata;
                rd_addr = AW'(CW'(r_sym) + CW'(1));
                n_state = S_CHI;
            end
            S_CHI: begin
                n_chi = r_tdata;
                if (r_total == '0) begin
                    n_status = ST_EMPTY;
                    n_state  = S_ORD;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod0 = PW'(range_w) * PW'(r_clo);
                n_prod1 = PW'(range_w) * PW'(r_chi);
                n_state = S_DIVS;
            end
            S_DIVS: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div0_done && div1_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (hi1_w <= lo_w || hi1_w > ((PW+1)'(1) << CB)) begin
                    n_status = ST_EMPTY;
                    n_state  = S_ORD;
                end else begin
                    n_low   = lo_w[CB-1:0];
                    n_high  = CB'(hi1_w - 1'b1);
                    n_open  = 1'b1;
                    n_state = S_REN;
                end
            end
            S_REN: begin
                if (r_low[CB-1] == r_high[CB-1]) begin
                    n_bit    = r_low[CB-1];
                    n_inv    = 1'b0;
                    n_follow = (PB+1)'(r_pend);
                    n_pend   = '0;
                    n_flush  = 1'b0;
                    n_low    = {r_low[CB-2:0], 1'b0};
                    n_high   = {r_high[CB-2:0], 1'b1};
                    n_state  = S_PUT;
                end else if (r_low[CB-2] && !r_high[CB-2]) begin
                    if (r_pend >= PB'(MAX_PENDING)) begin
                        n_status = ST_PEND;
                    end else begin
                        n_pend = r_pend + 1'b1;
                    end
                    n_low  = (r_low - Q1) << 1;
                    n_high = ((r_high - Q1) << 1) | CB'(1);
                end else begin
                    n_state = r_last ? S_FLUSH : S_ORD;
                end
            end
            S_FLUSH: begin
                n_bit    = r_low[CB-1] | r_low[CB-2];
                n_inv    = 1'b0;
                n_follow = (PB+1)'(r_pend) + 1'b1;
                n_pend   = '0;
                n_flush  = 1'b1;
                n_state  = S_PUT;
            end
            S_PUT: begin
                if (r_btg == 4'd1) begin
                    if (r_nres < RES_W'(MAX_RESULTS)) begin
                        rb_we  = 1'b1;
                        n_nres = r_nres + 1'b1;
                    end
                    if (r_bytes != '1) begin
                        n_bytes = r_bytes + 1'b1;
                    end
                    n_buf = '0;
                    n_btg = 4'd8;
                end else begin
                    n_buf = nb;
                    n_btg = r_btg - 1'b1;
                end
                if (r_follow == '0) begin
                    n_state = r_flush ? S_TAIL : S_REN;
                end else begin
                    n_inv    = 1'b1;
                    n_follow = r_follow - 1'b1;
                end
            end
            S_TAIL: begin
                rb_wd = r_buf << r_btg;
                if (r_btg != 4'd8 && r_nres < RES_W'(MAX_RESULTS)) begin
                    rb_we  = 1'b1;
                    n_nres = r_nres + 1'b1;
                end
                n_len   = (len_w[35:32] != '0) ? '1 : len_w[31:0];
                n_final = 1'b1;
                n_open  = 1'b0;
                n_low   = '0;
                n_high  = '1;
                n_buf   = '0;
                n_btg   = 4'd8;
                n_state = S_ORD;
            end
            S_ORD: begin
                n_state = S_OLD;
            end
            S_OLD: begin
                n_ovalid = 1'b1;
                n_obv    = (r_nres != '0);
                n_obyte  = (r_nres != '0) ? r_rbdata : 8'd0;
                n_oend   = islast && r_final;
                n_olen   = (islast && r_final) ? r_len : 32'd0;
                n_oeor   = islast;
                n_state  = S_OWAIT;
            end
            S_OWAIT: begin
                if (o_out.ready) begin
                    n_ovalid = 1'b0;
                    if (islast) begin
                        n_state = S_IDLE;
                    end else begin
                        n_oidx  = r_oidx + 1'b1;
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_low    <= '0;
            r_high   <= '1;
            r_pend   <= '0;
            r_buf    <= '0;
            r_btg    <= 4'd8;
            r_bytes  <= '0;
            r_open   <= 1'b0;
            r_nres   <= '0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
            r_status <= ST_OK;
            r_final  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_low    <= n_low;
            r_high   <= n_high;
            r_pend   <= n_pend;
            r_buf    <= n_buf;
            r_btg    <= n_btg;
            r_bytes  <= n_bytes;
            r_open   <= n_open;
            r_nres   <= n_nres;
            r_oidx   <= n_oidx;
            r_ovalid <= n_ovalid;
            r_status <= n_status;
            r_final  <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym    <= n_sym;
        r_last   <= n_last;
        r_total  <= n_total;
        r_clo    <= n_clo;
        r_chi    <= n_chi;
        r_prod0  <= n_prod0;
        r_prod1  <= n_prod1;
        r_bit    <= n_bit;
        r_inv    <= n_inv;
        r_flush  <= n_flush;
        r_follow <= n_follow;
        r_len    <= n_len;
        r_obyte  <= n_obyte;
        r_obv    <= n_obv;
        r_oend   <= n_oend;
        r_oeor   <= n_oeor;
        r_olen   <= n_olen;
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.byte_value = r_obyte;
    assign o_out.byte_valid = r_obv;
    assign o_out.status     = r_status;
    assign o_out.stream_end = r_oend;
    assign o_out.bit_length = r_olen;
    assign o_out.end_of_run = r_oeor;

    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= RES_W'(MAX_RESULTS))
        else $error("result count beyond buffer depth");

    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_state == S_OWAIT))
        else $error("result shown outside transfer state");

    a_tab_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tab_we |-> (r_state == S_IDLE))
        else $error("table written while busy");

    a_btg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_btg != 4'd0) && (r_btg <= 4'd8))
        else $error("bit counter out of range");

    a_div_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div0_done == div1_done)
        else $error("dividers out of step");

endmodule
`default_nettype wire

[hw/rtl/ase_div.sv]
`default_nettype none
module ase_div
    import ase_pkg::*;
#(
    parameter int NW = 33
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [NW-1:0]   i_dividend,
    input  wire logic [TV_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [NW-1:0]        o_quot
);
    localparam int CNT_W = $clog2(NW + 1);

    logic [TV_W:0]   r_rem;
    logic [NW-1:0]   r_q;
    logic [TV_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic            r_done;

    logic [TV_W:0] t;
    logic          ge;

    always_comb begin
        t  = {r_rem[TV_W-1:0], r_q[NW-1]};
        ge = t >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(NW);
                r_rem <= '0;
                r_q   <= i_dividend;
                r_div <= i_divisor;
            end else if (r_cnt != '0) begin
                r_rem <= ge ? (t - {1'b0, r_div}) : t;
                r_q   <= {r_q[NW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

[test/testbench.sv]
`default_nettype none
module testbench;
    import ase_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic        act;
        logic [8:0]  tidx;
        logic [15:0] tval;
        logic [7:0]  sym;
        logic        last;
    } t_item;

    typedef struct {
        logic [7:0]  bval;
        logic        bvalid;
        logic [1:0]  st;
        logic        send;
        logic [31:0] blen;
        logic        eor;
    } t_res;

    logic i_clk;
    logic i_rst_n;

    ase_cfg_if cfg_if ();
    ase_in_if  in_if ();
    ase_out_if out_if ();

    arithmetic_symbol_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_item item_q[$];
    t_res  byte_q[$];
    t_res  run_q[$];
    int    errors;
    int    send_idle;
    int    recv_idle;
    logic  in_fire;
    int    hold_req;
    int    hold_seen;
    int    hold_cnt;
    int    stall;

    // coder copy
    logic [8:0]      cfg_count;
    logic [2:0]      cfg_off;
    logic [7:0]      cfg_prefix;
    longint unsigned iv_lo;
    longint unsigned iv_hi;
    int unsigned     pend;
    logic [7:0]      bbuf;
    int unsigned     togo;
    int unsigned     nbytes;
    bit              open;
    logic [15:0]     freq_tbl [0:256];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void add_byte(logic [7:0] v);
        if (run_q.size() < MAX_RESULTS) run_q.push_back('{v, 1'b1, 2'd0, 1'b0, 32'd0, 1'b0});
    endfunction

    function automatic void put_bit(logic b);
        bbuf = {bbuf[6:0], b};
        if (togo > 0) togo--;
        if (togo == 0) begin
            add_byte(bbuf);
            if (nbytes != 32'hFFFF_FFFF) nbytes++;
            bbuf = 8'd0;
            togo = 8;
        end
    endfunction

    function automatic void put_bits(logic b, int unsigned follow);
        put_bit(b);
        repeat (follow) put_bit(~b);
    endfunction

    function automatic void predict_item(t_item it);
        logic [1:0]      st;
        bit              fin;
        longint          ln;
        int unsigned     cnt;
        longint unsigned total, range, lo, hi1, hi;
        st = ST_OK;
        fin = 0;
        ln = 0;
        run_q.delete();
        if (it.act == ACT_WRITE) begin
            if (it.tidx <= 256) freq_tbl[it.tidx] = it.tval;
        end else begin
            cnt = (cfg_count > 256) ? 256 : cfg_count;
            if (it.sym >= cnt) begin
                st = ST_RANGE;
            end else begin
                if (!open) begin
                    iv_lo = 0;
                    iv_hi = 65535;
                    pend = 0;
                    nbytes = 0;
                    togo = 8 - cfg_off;
                    bbuf = (cfg_off != 0) ? 8'(cfg_prefix >> (8 - cfg_off)) : 8'd0;
                end
                total = freq_tbl[cnt];
                range = iv_hi - iv_lo + 1;
                if (total == 0) begin
                    st = ST_EMPTY;
                end else begin
                    lo  = iv_lo + (range * freq_tbl[it.sym]) / total;
                    hi1 = iv_lo + (range * freq_tbl[it.sym + 1]) / total;
                    if (hi1 <= lo || hi1 > 65536) begin
                        st = ST_EMPTY;
                    end else begin
                        hi = hi1 - 1;
                        open = 1;
                        forever begin
                            if (((lo ^ hi) & 32768) == 0) begin
                                put_bits(lo[15], pend);
                                pend = 0;
                                lo &= 32767;
                                hi &= 32767;
                            end else if (lo >= 16384 && hi < 49152) begin
                                if (pend >= 127) st = ST_PEND;
                                else pend++;
                                lo -= 16384;
                                hi -= 16384;
                            end else begin
                                break;
                            end
                            lo = (lo << 1) & 65535;
                            hi = ((hi << 1) | 1) & 65535;
                        end
                        iv_lo = lo;
                        iv_hi = hi;
                        if (it.last) begin
                            put_bits(iv_lo >= 16384, pend + 1);
                            pend = 0;
                            if (togo != 8) add_byte(8'(16'(bbuf) << togo));
                            ln = longint'(nbytes) * 8 + (8 - togo) - cfg_off;
                            if (ln > 64'hFFFF_FFFF) ln = 64'hFFFF_FFFF;
                            fin = 1;
                            open = 0;
                            iv_lo = 0;
                            iv_hi = 65535;
                            bbuf = 8'd0;
                            togo = 8;
                        end
                    end
                end
            end
        end
        if (run_q.size() == 0) run_q.push_back('{8'd0, 1'b0, 2'd0, 1'b0, 32'd0, 1'b0});
        foreach (run_q[k]) run_q[k].st = st;
        if (fin) begin
            run_q[$].send = 1'b1;
            run_q[$].blen = 32'(ln);
        end
        run_q[$].eor = 1'b1;
        foreach (run_q[k]) byte_q.push_back(run_q[k]);
    endfunction

    always @(posedge i_clk) begin
        t_res e;
        in_fire <= in_if.valid && in_if.ready;
        if (cfg_if.valid && cfg_if.ready) begin
            case (cfg_if.index)
                CFG_SYMBOL_COUNT: cfg_count = cfg_if.data;
                CFG_START_OFFSET: cfg_off = cfg_if.data[2:0];
                CFG_START_PREFIX: cfg_prefix = cfg_if.data[7:0];
                default: ;
            endcase
        end
        if (in_if.valid && in_if.ready)
            predict_item('{in_if.action, in_if.table_index, in_if.table_value,
                           in_if.symbol, in_if.last});
        if (out_if.valid && out_if.ready) begin
            if (byte_q.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                e = byte_q.pop_front();
                if (out_if.byte_value !== e.bval) begin
                    $error("byte_value exp %0h act %0h", e.bval, out_if.byte_value);
                    errors++;
                end
                if (out_if.byte_valid !== e.bvalid) begin
                    $error("byte_valid exp %0h act %0h", e.bvalid, out_if.byte_valid);
                    errors++;
                end
                if (out_if.status !== e.st) begin
                    $error("status exp %0h act %0h", e.st, out_if.status);
                    errors++;
                end
                if (out_if.stream_end !== e.send) begin
                    $error("stream_end exp %0h act %0h", e.send, out_if.stream_end);
                    errors++;
                end
                if (out_if.bit_length !== e.blen) begin
                    $error("bit_length exp %0h act %0h", e.blen, out_if.bit_length);
                    errors++;
                end
                if (out_if.end_of_run !== e.eor) begin
                    $error("end_of_run exp %0h act %0h", e.eor, out_if.end_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            stall <= 0;
        end else if (stall >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall <= stall + 1;
        end
    end

    always @(negedge i_clk) begin
        t_item it;
        if (!in_if.valid || in_fire) begin
            if (item_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                it = item_q.pop_front();
                in_if.action      <= it.act;
                in_if.table_index <= it.tidx;
                in_if.table_value <= it.tval;
                in_if.symbol      <= it.sym;
                in_if.last        <= it.last;
                in_if.valid       <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen    <= hold_req;
            hold_cnt     <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt     <= hold_cnt - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic cfg_write(t_cfg_index idx, logic [8:0] d);
        @(negedge i_clk);
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (item_q.size() != 0 || in_if.valid || byte_q.size() != 0);
        repeat (10) @(negedge i_clk);
    endtask

    function automatic void push_write(int idx, int val);
        item_q.push_back('{ACT_WRITE, 9'(idx), 16'(val), 8'd0, 1'b0});
    endfunction

    function automatic void push_enc(int s, bit l);
        item_q.push_back('{ACT_ENCODE, 9'd0, 16'd0, 8'(s), l});
    endfunction

    function automatic void push_table(int n);
        int acc;
        int wmax;
        acc = 0;
        wmax = 65535 / n;
        push_write(0, 0);
        for (int i = 1; i <= n; i++) begin
            if ($urandom_range(19) != 0) acc += $urandom_range(1, wmax);
            push_write(i, acc);
        end
    endfunction

    function automatic void push_random(int cnt);
        int r;
        r = $urandom_range(99);
        if (r < 3) push_write($urandom_range(511), $urandom_range(65535));
        else if (r < 6) push_write($urandom_range(cnt), $urandom_range(65535));
        else if (r < 12 && cnt < 256) push_enc($urandom_range(255, cnt), $urandom_range(1));
        else push_enc($urandom_range(cnt - 1), $urandom_range(9) == 0);
    endfunction

    int ph_count [5] = '{24, 1, 7, 12, 40};
    int ph_off   [5] = '{0, 7, 3, 1, 4};
    int ph_pre   [5] = '{0, 255, 8'hA5, 8'h80, 8'h3C};

    initial begin
        int eff;
        errors = 0;
        send_idle = 28;
        recv_idle = 62;
        hold_req = 0;
        hold_seen = 0;
        hold_cnt = 0;
        stall = 0;
        in_fire = 1'b0;
        open = 0;
        iv_lo = 0;
        iv_hi = 65535;
        pend = 0;
        bbuf = 8'd0;
        togo = 8;
        nbytes = 0;
        cfg_count = 9'd256;
        cfg_off = 3'd0;
        cfg_prefix = 8'd0;
        i_rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_SYMBOL_COUNT;
        cfg_if.data = 9'd0;
        in_if.valid = 1'b0;
        in_if.action = ACT_WRITE;
        in_if.table_index = 9'd0;
        in_if.table_value = 16'd0;
        in_if.symbol = 8'd0;
        in_if.last = 1'b0;
        out_if.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero count, range errors, pending saturation, empty intervals,
        // symbol count above the table size
        cfg_write(CFG_SYMBOL_COUNT, 9'd0);
        push_enc(0, 1);
        wait_idle();
        cfg_write(CFG_SYMBOL_COUNT, 9'd3);
        cfg_write(CFG_START_OFFSET, 9'd5);
        cfg_write(CFG_START_PREFIX, 9'hFF);
        push_write(0, 0);
        push_write(1, 32766);
        push_write(2, 32769);
        push_write(3, 65535);
        push_write(300, 123);
        push_write(511, 65535);
        repeat (10) push_enc(1, 0);
        push_enc(1, 1);
        push_enc(0, 1);
        push_enc(2, 0);
        push_enc(2, 1);
        push_enc(255, 0);
        push_enc(3, 1);
        push_write(3, 0);
        push_enc(0, 1);
        push_write(3, 65535);
        push_write(2, 1);
        push_enc(1, 1);
        wait_idle();
        cfg_write(CFG_SYMBOL_COUNT, 9'd300);
        push_write(0, 0);
        push_write(1, 40000);
        push_write(256, 65535);
        push_enc(0, 1);
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            if (p == 2) begin
                send_idle = 62;
                recv_idle = 28;
            end else if (p == 4) begin
                send_idle = 0;
                recv_idle = 0;
            end
            cfg_write(CFG_SYMBOL_COUNT, 9'(ph_count[p]));
            cfg_write(CFG_START_OFFSET, 9'(ph_off[p]));
            cfg_write(CFG_START_PREFIX, 9'(ph_pre[p]));
            eff = (ph_count[p] > 256) ? 256 : ph_count[p];
            push_table(eff);
            wait_idle();
            repeat (10) push_random(eff);
            if (p == 1) hold_req++;
            if (p == 2) wait_idle();
            repeat (10) push_random(eff);
            wait_idle();
        end

        repeat (50) @(negedge i_clk);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
